// ===== rtl/imu_frame_deframer_decoder_core_assert.svh =====
// ---------------------------------------------------------------------------
// IMU deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ---------------------------------------------------------------------------
`ifndef IMU_FRAME_DEFRAMER_DECODER_CORE_ASSERT_SVH
`define IMU_FRAME_DEFRAMER_DECODER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define IFD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a condition in the same cycle as its trigger.
`define IFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define IFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/imu_ffd_pkg.sv =====
// ---------------------------------------------------------------------------
// IMU deframer package
// Frame layout constants, register indexes and the decoded frame type.
// ---------------------------------------------------------------------------
`default_nettype none

package imu_ffd_pkg;

  localparam int FRAME_LEN = 14;
  localparam int FILL_W    = $clog2(FRAME_LEN);
  localparam int WIN_W     = (FRAME_LEN - 1) * 8;
  localparam int FULL_W    = FRAME_LEN * 8;

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_LEN - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_LEN);

  localparam logic [7:0] FRAME_HEAD = 8'hFF;
  localparam logic [7:0] FRAME_TAIL = 8'h0D;

  // Byte positions inside a frame
  localparam int POS_W     = 1;
  localparam int POS_X     = 3;
  localparam int POS_Y     = 5;
  localparam int POS_Z     = 7;
  localparam int POS_SPEED = 9;
  localparam int POS_MODE  = 11;
  localparam int POS_COLOR = 12;

  localparam int SQ_W  = 31;
  localparam int SUM_W = 33;
  localparam logic [SUM_W-1:0] NORM_LOW  = SUM_W'(90000000);
  localparam logic [SUM_W-1:0] NORM_HIGH = SUM_W'(110000000);

  localparam int SPEED_W = 18;
  localparam logic signed [15:0]        SPEED_LIMIT = 16'sd1000;
  localparam logic signed [SPEED_W-1:0] SPEED_SCALE = 18'sd100;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_FORCED  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED_VALUE = 8'd1;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] speed;
    logic [7:0]  mode;
    logic [7:0]  color;
    logic        color_changed;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/imu_ffd_window.sv =====
// ---------------------------------------------------------------------------
// IMU deframer byte window
// Collects bytes behind a header, checks the trailer, on a miss slides to
// the next header or empties, and registers a complete frame for decoding.
// ---------------------------------------------------------------------------
`default_nettype none

module imu_ffd_window (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                mode_forced,
  input  wire logic [7:0]          forced_mode_value,
  input  wire logic                a_take,
  output logic                     a_valid,
  output imu_ffd_pkg::frame_t      a_frame
);
  import imu_ffd_pkg::*;

  `include "imu_frame_deframer_decoder_core_assert.svh"

  logic [WIN_W-1:0]  win;
  logic [WIN_W-1:0]  win_next;
  logic [FILL_W-1:0] window_fill;
  logic [FILL_W-1:0] window_fill_next;
  logic [7:0]        last_color;
  logic [FULL_W-1:0] full;
  logic [FULL_W-1:0] shifted;
  logic [FILL_W-1:0] shift_k;
  logic              found;
  logic              frame_hit;
  frame_t            frame_next;

  assign full      = {rx_byte, win};
  assign shifted   = full >> {shift_k, 3'b000};
  assign frame_hit = accept && (window_fill == FILL_LAST) && (rx_byte == FRAME_TAIL);

  // Find the first header after position zero
  always_comb begin
    shift_k = '0;
    found   = 1'b0;
    for (int i = FRAME_LEN - 1; i >= 1; i--) begin
      if (full[i*8 +: 8] == FRAME_HEAD) begin
        shift_k = FILL_W'(i);
        found   = 1'b1;
      end
    end
  end

  always_comb begin
    win_next         = win;
    window_fill_next = window_fill;
    if (accept) begin
      if (window_fill == '0 && rx_byte != FRAME_HEAD) begin
        window_fill_next = '0;
      end else if (window_fill != FILL_LAST) begin
        for (int j = 0; j < FRAME_LEN - 1; j++) begin
          if (window_fill == FILL_W'(j)) begin
            win_next[j*8 +: 8] = rx_byte;
          end
        end
        window_fill_next = window_fill + 1'b1;
      end else if (rx_byte == FRAME_TAIL) begin
        window_fill_next = '0;
      end else if (found) begin
        win_next         = shifted[WIN_W-1:0];
        window_fill_next = FILL_FULL - shift_k;
      end else begin
        window_fill_next = '0;
      end
    end
  end

  always_comb begin
    frame_next.w             = {full[(POS_W+1)*8 +: 8], full[POS_W*8 +: 8]};
    frame_next.x             = {full[(POS_X+1)*8 +: 8], full[POS_X*8 +: 8]};
    frame_next.y             = {full[(POS_Y+1)*8 +: 8], full[POS_Y*8 +: 8]};
    frame_next.z             = {full[(POS_Z+1)*8 +: 8], full[POS_Z*8 +: 8]};
    frame_next.speed         = {full[(POS_SPEED+1)*8 +: 8], full[POS_SPEED*8 +: 8]};
    frame_next.mode          = mode_forced ? forced_mode_value : full[POS_MODE*8 +: 8];
    frame_next.color         = full[POS_COLOR*8 +: 8];
    frame_next.color_changed = (full[POS_COLOR*8 +: 8] != last_color);
  end

  always_ff @(posedge clk) begin
    win <= win_next;
    if (frame_hit) begin
      a_frame <= frame_next;
    end
    if (rst) begin
      window_fill <= '0;
      last_color  <= '0;
      a_valid     <= 1'b0;
    end else begin
      window_fill <= window_fill_next;
      if (frame_hit) begin
        last_color <= frame_next.color;
        a_valid    <= 1'b1;
      end else if (a_take) begin
        a_valid <= 1'b0;
      end
    end
  end

  `IFD_ASSERT_ALWAYS(a_fill_range, window_fill <= FILL_LAST, "window fill out of range")
  `IFD_ASSERT_SAME(a_head_first, window_fill != '0, win[7:0] == FRAME_HEAD,
    "window does not start with a header")
  `IFD_ASSERT_NEXT(a_frame_load, frame_hit,
    a_valid && window_fill == '0 && last_color == a_frame.color,
    "frame load did not update stage or color")

endmodule

`default_nettype wire

// ===== rtl/imu_ffd_norm.sv =====
// ---------------------------------------------------------------------------
// IMU deframer decode pipeline
// Squares the quaternion words, checks the norm window, scales small speeds
// and holds the result word for the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module imu_ffd_norm (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       a_valid,
  input  wire imu_ffd_pkg::frame_t        a_frame,
  output logic                            a_take,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output imu_ffd_pkg::frame_t             out_frame,
  output logic                            out_ok,
  output logic [imu_ffd_pkg::SPEED_W-1:0] out_speed
);
  import imu_ffd_pkg::*;

  `include "imu_frame_deframer_decoder_core_assert.svh"

  logic               b_valid;
  frame_t             b_frame;
  logic [SQ_W-1:0]    b_sq_w;
  logic [SQ_W-1:0]    b_sq_x;
  logic [SQ_W-1:0]    b_sq_y;
  logic [SQ_W-1:0]    b_sq_z;
  logic [SPEED_W-1:0] b_speed;
  logic [SUM_W-1:0]   sum;
  logic               o_free;
  logic               b_free;
  logic signed [31:0] prod_w;
  logic signed [31:0] prod_x;
  logic signed [31:0] prod_y;
  logic signed [31:0] prod_z;
  logic signed [SPEED_W-1:0] speed_ext;
  logic signed [SPEED_W-1:0] speed_scaled;
  logic               speed_big;

  assign o_free = !out_valid || !out_stall;
  assign b_free = !b_valid || o_free;
  assign a_take = b_free;

  assign prod_w = $signed(a_frame.w) * $signed(a_frame.w);
  assign prod_x = $signed(a_frame.x) * $signed(a_frame.x);
  assign prod_y = $signed(a_frame.y) * $signed(a_frame.y);
  assign prod_z = $signed(a_frame.z) * $signed(a_frame.z);

  assign speed_ext    = SPEED_W'($signed(a_frame.speed));
  assign speed_scaled = speed_ext * SPEED_SCALE;
  assign speed_big    = ($signed(a_frame.speed) >= SPEED_LIMIT) ||
                        ($signed(a_frame.speed) <= -SPEED_LIMIT);

  assign sum = SUM_W'(b_sq_w) + SUM_W'(b_sq_x) + SUM_W'(b_sq_y) + SUM_W'(b_sq_z);

  always_ff @(posedge clk) begin
    if (a_valid && b_free) begin
      b_frame <= a_frame;
      b_sq_w  <= prod_w[SQ_W-1:0];
      b_sq_x  <= prod_x[SQ_W-1:0];
      b_sq_y  <= prod_y[SQ_W-1:0];
      b_sq_z  <= prod_z[SQ_W-1:0];
      b_speed <= speed_big ? speed_ext : speed_scaled;
    end
    if (b_valid && o_free) begin
      out_frame <= b_frame;
      out_ok    <= (sum >= NORM_LOW) && (sum <= NORM_HIGH);
      out_speed <= b_speed;
    end
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (o_free) begin
        out_valid <= b_valid;
      end
    end
  end

  `IFD_ASSERT_NEXT(a_b_hold, b_valid && !o_free, b_valid && $stable(b_sq_w) && $stable(b_speed),
    "square stage lost its word while stalled")
  `IFD_ASSERT_NEXT(a_b_move, b_valid && o_free, out_valid, "square stage word not delivered")
  `IFD_ASSERT_SAME(a_speed_range, out_valid,
    $signed(out_speed) <= 18'sd99900 && $signed(out_speed) >= -18'sd99900,
    "speed outside scaled range")

endmodule

`default_nettype wire

// ===== rtl/imu_frame_deframer_decoder_core.sv =====
// ---------------------------------------------------------------------------
// IMU frame deframer and decoder
// Finds 14-byte header/trailer frames in a received byte stream and decodes
// quaternion, norm check, bullet speed, mode and enemy color.
// ---------------------------------------------------------------------------
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, rx_byte               | byte words in
//   out     | out_valid, out_stall, quat_*, speed_centi, | decoded word out
//           | mode_out, color_out, color_changed        |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | register writes
//
// A byte is taken every cycle while in_stall is low; the window update and
// trailer check run in the cycle of arrival. After the trailer byte a decoded
// word passes the frame register, square register and result register.
// Reset (rst, synchronous) empties the window, clears the stored color and
// the pipeline valids, and sets both config registers to zero.
// A stalled output keeps taking bytes while the frame and square stages
// have room; in_stall rises only when the frame register is held.
// ---------------------------------------------------------------------------
`default_nettype none

module imu_frame_deframer_decoder_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // byte input
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   rx_byte,
  // decoded output
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [15:0]                quat_w,
  output logic signed [15:0]                quat_x,
  output logic signed [15:0]                quat_y,
  output logic signed [15:0]                quat_z,
  output logic                              quat_ok,
  output logic signed [17:0]                speed_centi,
  output logic [7:0]                        mode_out,
  output logic [7:0]                        color_out,
  output logic                              color_changed,
  // configuration writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [imu_ffd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                   cfg_data
);
  import imu_ffd_pkg::*;

  logic   mode_forced;
  logic [7:0] forced_mode_value;
  logic   a_valid;
  logic   a_take;
  frame_t a_frame;
  frame_t out_frame;
  logic   out_ok;
  logic [SPEED_W-1:0] out_speed;
  logic   accept;

  // Registers are always writable; unknown indexes drop the word.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_forced       <= 1'b0;
      forced_mode_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE_FORCED:  mode_forced       <= cfg_data[0];
        CFG_FORCED_VALUE: forced_mode_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold input bytes only while a finished frame cannot leave its register.
  assign in_stall = a_valid && !a_take;
  assign accept   = in_valid && !in_stall;

  imu_ffd_window u_window (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .rx_byte           (rx_byte),
    .mode_forced       (mode_forced),
    .forced_mode_value (forced_mode_value),
    .a_take            (a_take),
    .a_valid           (a_valid),
    .a_frame           (a_frame)
  );

  imu_ffd_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .a_valid   (a_valid),
    .a_frame   (a_frame),
    .a_take    (a_take),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_frame (out_frame),
    .out_ok    (out_ok),
    .out_speed (out_speed)
  );

  assign quat_w        = out_frame.w;
  assign quat_x        = out_frame.x;
  assign quat_y        = out_frame.y;
  assign quat_z        = out_frame.z;
  assign quat_ok       = out_ok;
  assign speed_centi   = out_speed;
  assign mode_out      = out_frame.mode;
  assign color_out     = out_frame.color;
  assign color_changed = out_frame.color_changed;

endmodule

`default_nettype wire

// ===== verif/tb_imu_frame_deframer_decoder_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IMU frame deframer and decoder testbench
// Streams framed and broken byte sequences into the deframer under random
// flow control. A behavioral deframer mirrors the window, the stored color
// and the mode registers, and each decoded word is checked field by field.
// ---------------------------------------------------------------------------

module tb_imu_frame_deframer_decoder_core;

  import imu_ffd_pkg::*;

  // Register indexes that the block does not implement; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

  // Pipeline is three stages deep; drain() then idles for SETTLE_CYCLES
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 280;

  // One decoded frame as the output ports present it
  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               ok;
    logic signed [17:0] speed;
    logic [7:0]         mode;
    logic [7:0]         color;
    logic               changed;
  } frame_result_t;

  // -------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // -------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte   = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [15:0]   quat_w;
  logic signed [15:0]   quat_x;
  logic signed [15:0]   quat_y;
  logic signed [15:0]   quat_z;
  logic                 quat_ok;
  logic signed [17:0]   speed_centi;
  logic [7:0]           mode_out;
  logic [7:0]           color_out;
  logic                 color_changed;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = 8'h00;

  imu_frame_deframer_decoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .quat_w        (quat_w),
    .quat_x        (quat_x),
    .quat_y        (quat_y),
    .quat_z        (quat_z),
    .quat_ok       (quat_ok),
    .speed_centi   (speed_centi),
    .mode_out      (mode_out),
    .color_out     (color_out),
    .color_changed (color_changed),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Testbench state
  // -------------------------------------------------------------------------
  logic [7:0]    byte_feed[$];       // bytes waiting to be driven
  frame_result_t pending_frames[$];  // decoded words still owed by the block

  // Mirror of the block: receive window, stored color and mode registers
  logic [7:0] win [FRAME_LEN];
  int         win_fill         = 0;
  logic [7:0] seen_color       = 8'h00;
  logic       mirror_force_en  = 1'b0;
  logic [7:0] mirror_force_val = 8'h00;

  bit         calm        = 1'b0;  // set for the closing stretch: no gaps, no stalls
  int         gap_left    = 0;
  int         stall_left  = 0;
  int         idle_cycles = 0;
  logic [7:0] gen_color   = 8'h00; // last color handed to the generator

  int bytes_queued   = 0;
  int bytes_taken    = 0;
  int frames_checked = 0;
  int frames_norm_ok = 0;
  int frames_forced  = 0;
  int resyncs        = 0;
  int cfg_writes     = 0;
  int mismatches     = 0;

  // -------------------------------------------------------------------------
  // Behavioral deframer: advance the window by one accepted byte and queue
  // the decoded word when a frame closes
  // -------------------------------------------------------------------------
  task automatic deframe_byte(input logic [7:0] b);
    int            k;
    int            qw, qx, qy, qz, spv;
    longint        norm_sq;
    frame_result_t res;
    bytes_taken++;
    // Outside a frame, drop everything that is not a header
    if (win_fill == 0 && b != FRAME_HEAD) return;
    win[win_fill] = b;
    win_fill++;
    if (win_fill < FRAME_LEN) return;

    if (win[FRAME_LEN-1] != FRAME_TAIL) begin
      // No trailer: drop the leading header and slide to the next one
      k = 1;
      while (k < win_fill && win[k] != FRAME_HEAD) k++;
      for (int i = 0; i + k < win_fill; i++) win[i] = win[i + k];
      win_fill = (k >= win_fill) ? 0 : win_fill - k;
      resyncs++;
      return;
    end

    qw  = $signed({win[POS_W + 1],     win[POS_W]});
    qx  = $signed({win[POS_X + 1],     win[POS_X]});
    qy  = $signed({win[POS_Y + 1],     win[POS_Y]});
    qz  = $signed({win[POS_Z + 1],     win[POS_Z]});
    spv = $signed({win[POS_SPEED + 1], win[POS_SPEED]});
    norm_sq = longint'(qw) * qw + longint'(qx) * qx + longint'(qy) * qy + longint'(qz) * qz;

    res.w  = qw[15:0];
    res.x  = qx[15:0];
    res.y  = qy[15:0];
    res.z  = qz[15:0];
    res.ok = (norm_sq >= longint'(NORM_LOW)) && (norm_sq <= longint'(NORM_HIGH));
    // Large raw values are already in centi units; small ones are whole m/s
    if (spv >= int'(SPEED_LIMIT) || spv <= -int'(SPEED_LIMIT))
      res.speed = spv[17:0];
    else
      res.speed = 18'(spv * int'(SPEED_SCALE));
    res.mode    = mirror_force_en ? mirror_force_val : win[POS_MODE];
    res.color   = win[POS_COLOR];
    res.changed = (win[POS_COLOR] != seen_color);
    seen_color  = win[POS_COLOR];
    win_fill    = 0;
    if (res.ok) frames_norm_ok++;
    if (mirror_force_en) frames_forced++;
    pending_frames = {pending_frames, res};
  endtask

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------
  task automatic cmp_field(input string fname, input logic signed [63:0] want,
                           input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  task automatic check_frame();
    frame_result_t want;
    if (pending_frames.size() == 0) begin
      $display("%0t: decoded word with nothing expected (w=%0d color=%0d)",
               $time, quat_w, color_out);
      mismatches++;
    end else begin
      want = pending_frames.pop_front();
      cmp_field("quat_w",        want.w,       quat_w);
      cmp_field("quat_x",        want.x,       quat_x);
      cmp_field("quat_y",        want.y,       quat_y);
      cmp_field("quat_z",        want.z,       quat_z);
      cmp_field("quat_ok",       want.ok,      quat_ok);
      cmp_field("speed_centi",   want.speed,   speed_centi);
      cmp_field("mode_out",      want.mode,    mode_out);
      cmp_field("color_out",     want.color,   color_out);
      cmp_field("color_changed", want.changed, color_changed);
      frames_checked++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: hold a stalled word, otherwise advance to the next byte or idle
  // for a short burst
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (!calm && byte_feed.size() != 0 && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (byte_feed.size() != 0) begin
        in_valid <= 1'b1;
        rx_byte  <= byte_feed.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on every accepted byte before checking, so ordering
  // within the edge never matters
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) deframe_byte(rx_byte);
      if (out_valid && !out_stall) check_frame();
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d decoded words outstanding",
                 $time, WATCHDOG_LIMIT, pending_frames.size());
        $display("tb_imu_frame_deframer_decoder_core: errors");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // Register taken at this edge; mirror it
    case (idx)
      CFG_MODE_FORCED:  mirror_force_en  = data[0];
      CFG_FORCED_VALUE: mirror_force_val = data;
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Let the sender run dry, collect every owed word, then let the pipe settle
  task automatic drain();
    while (byte_feed.size() != 0 || in_valid) @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    byte_feed = {byte_feed, b};
    bytes_queued++;
  endtask

  task automatic queue_frame(input logic [15:0] w, x, y, z, sp,
                             input logic [7:0] mode, color, tail);
    queue_byte(FRAME_HEAD);
    queue_byte(w[7:0]);  queue_byte(w[15:8]);
    queue_byte(x[7:0]);  queue_byte(x[15:8]);
    queue_byte(y[7:0]);  queue_byte(y[15:8]);
    queue_byte(z[7:0]);  queue_byte(z[15:8]);
    queue_byte(sp[7:0]); queue_byte(sp[15:8]);
    queue_byte(mode);
    queue_byte(color);
    queue_byte(tail);
  endtask

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic logic [15:0] rand_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return r[15:0];
    endcase
  endfunction

  // Speeds cluster around the centi/whole boundary
  function automatic logic [15:0] rand_speed();
    int          v;
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: v = $signed(r[15:0]);
      1: begin v = $urandom_range(0, 1998); v = v - 999; end
      2: begin
        case ($urandom_range(0, 3))
          0:       v = 999;
          1:       v = 1000;
          2:       v = -999;
          default: v = -1000;
        endcase
      end
      default: begin v = $urandom_range(0, 6000); v = v - 3000; end
    endcase
    return v[15:0];
  endfunction

  // Repeat the last color now and then so the changed flag also stays low
  function automatic logic [7:0] pick_color();
    case ($urandom_range(0, 3))
      0:       ;
      1:       gen_color = 8'd1;
      2:       gen_color = 8'd2;
      default: gen_color = rand_byte();
    endcase
    return gen_color;
  endfunction

  function automatic logic [7:0] bad_tail();
    logic [7:0] b;
    b = rand_byte();
    if (b == FRAME_TAIL) b = b ^ 8'h01;
    return b;
  endfunction

  // Quaternion near unit norm, jittered so it lands on both sides of the band
  task automatic near_unit(output logic [15:0] w, x, y, z);
    int  a, b, c, d, j;
    real rest;
    a = $urandom_range(0, 10000); a = a - 5000;
    b = $urandom_range(0, 8000);  b = b - 4000;
    c = $urandom_range(0, 8000);  c = c - 4000;
    rest = 1.0e8 - real'(a * a + b * b + c * c);
    d = int'($sqrt(rest));
    j = $urandom_range(0, 1200);
    d = d + j - 600;
    if ($urandom_range(0, 1) == 1) d = -d;
    w = d[15:0];
    x = a[15:0];
    y = b[15:0];
    z = c[15:0];
  endtask

  // Mostly well-formed frames with random content; the rest broken frames,
  // truncated frames, loose noise and frames laced with header bytes
  task automatic random_traffic(input int n);
    int          stop_at, kind, len;
    logic [15:0] w, x, y, z;
    stop_at = bytes_queued + n;
    while (bytes_queued < stop_at) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 4) begin
        near_unit(w, x, y, z);
      end else begin
        w = rand_word(); x = rand_word(); y = rand_word(); z = rand_word();
      end
      if (kind < 70) begin
        queue_frame(w, x, y, z, rand_speed(), rand_byte(), pick_color(), FRAME_TAIL);
      end else if (kind < 78) begin
        queue_frame(w, x, y, z, rand_speed(), rand_byte(), pick_color(), bad_tail());
      end else if (kind < 86) begin
        queue_byte(FRAME_HEAD);
        len = $urandom_range(1, 12);
        repeat (len) queue_byte(rand_byte());
      end else if (kind < 94) begin
        len = $urandom_range(1, 6);
        repeat (len) queue_byte(rand_byte());
      end else begin
        queue_frame(16'hFFFF, {FRAME_HEAD, x[7:0]}, y, {FRAME_TAIL, FRAME_HEAD},
                    rand_speed(), FRAME_HEAD, pick_color(), FRAME_TAIL);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Start from the reset settings, written explicitly
    cfg_write(CFG_MODE_FORCED,  8'h00);
    cfg_write(CFG_FORCED_VALUE, 8'h00);

    // Directed part
    // Bytes outside a frame are dropped, the trailer value included
    queue_byte(8'h00); queue_byte(FRAME_TAIL); queue_byte(8'h7F);
    // Unit quaternion, small speed scaled up, first color differs from reset
    queue_frame(16'd10000, 16'd0, 16'd0, 16'd0, 16'd500, 8'h00, 8'd1, FRAME_TAIL);
    // Extreme components, extreme speed, same color again
    queue_frame(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 8'hFF, 8'd1, FRAME_TAIL);
    // Norm band edges, exactly on and just outside each limit
    queue_frame(16'd9000, 16'd3000, 16'd0, 16'd0, 16'd999, 8'h01, 8'd2, FRAME_TAIL);
    queue_frame(16'd9000, 16'd2999, 16'd0, 16'd0, -16'sd999, 8'h02, 8'd2, FRAME_TAIL);
    queue_frame(16'd10000, 16'd3000, 16'd1000, 16'd0, 16'd1000, 8'h03, 8'd0, FRAME_TAIL);
    queue_frame(16'd10000, 16'd3000, 16'd1000, 16'd1, -16'sd1000, 8'h04, 8'h55, FRAME_TAIL);
    queue_frame(16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF, 8'h00, 8'h00, FRAME_TAIL);
    queue_frame(16'd0, 16'd10000, 16'd0, 16'd0, 16'hFFFF, 8'h80, 8'd2, FRAME_TAIL);
    // Missing trailer with no header inside: window empties
    queue_frame(16'h2120, 16'h2322, 16'h2524, 16'h2726, 16'h2928, 8'h2A, 8'h2B, 8'h0C);
    // Missing trailer with a header inside: slide onto it and finish that frame
    queue_byte(FRAME_HEAD);
    queue_byte(8'h11); queue_byte(8'h22); queue_byte(8'h33); queue_byte(8'h44);
    queue_frame(16'd0, 16'd0, 16'd10000, 16'h0100, 16'd42, 8'h06, 8'd1, FRAME_TAIL);
    // Run of headers ahead of a frame: resync one header at a time
    queue_byte(FRAME_HEAD); queue_byte(FRAME_HEAD);
    queue_frame(16'd0, 16'd0, 16'd0, 16'd10000, 16'd1234, 8'h05, 8'd2, FRAME_TAIL);
    drain();

    // Forced mode at its top value
    cfg_write(CFG_FORCED_VALUE, 8'hFF);
    cfg_write(CFG_MODE_FORCED,  8'h01);
    queue_frame(16'd10000, 16'd0, 16'd0, 16'd0, 16'd7, 8'h12, 8'd1, FRAME_TAIL);

    // Random part in phases with the registers changed in between
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) calm = 1'b1;
      random_traffic(PHASE_BYTES / 2);
      // Hold the sender once mid-phase until every owed word is back
      if (ph == 1) drain();
      random_traffic(PHASE_BYTES / 2);
      drain();
      case (ph)
        0: begin
          cfg_write(CFG_MODE_FORCED, 8'hFE);   // bit 0 clear: forcing off
          cfg_write(CFG_IDX_TOP, rand_byte());
          cfg_write(CFG_FORCED_VALUE, rand_byte());
        end
        1: begin
          cfg_write(CFG_FORCED_VALUE, 8'h00);
          cfg_write(CFG_MODE_FORCED, 8'hFF);
        end
        2: begin
          cfg_write(CFG_IDX_SPARE, rand_byte());
          cfg_write(CFG_MODE_FORCED, rand_byte());
          cfg_write(CFG_FORCED_VALUE, rand_byte());
        end
        3: begin
          cfg_write(CFG_FORCED_VALUE, rand_byte());
          cfg_write(CFG_MODE_FORCED, 8'h01);
        end
        4: cfg_write(CFG_MODE_FORCED, 8'h00);
        default: ;
      endcase
    end

    $display("summary: %0d bytes taken, %0d frames checked, %0d inside the norm band",
             bytes_taken, frames_checked, frames_norm_ok);
    $display("summary: %0d with forced mode, %0d header resyncs, %0d register writes",
             frames_forced, resyncs, cfg_writes);
    if (mismatches == 0) begin
      $display("tb_imu_frame_deframer_decoder_core: clean");
    end else begin
      $display("tb_imu_frame_deframer_decoder_core: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/imu_ffd_pkg.sv
rtl/imu_ffd_window.sv
rtl/imu_ffd_norm.sv
rtl/imu_frame_deframer_decoder_core.sv
verif/tb_imu_frame_deframer_decoder_core.sv
